>>> hw/rtl/rrv_pkg.sv
`default_nettype none
package rrv_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE_VAL = 1 << FRAC_BITS;
  localparam logic signed [63:0] ONE_S64 = 64'sd1 <<< FRAC_BITS;

  localparam int U_W = FRAC_BITS + 2;
  localparam int MAG_W = 16;
  localparam int SQR_W = 31;
  localparam int SUM_W = 32;
  localparam int LEN_SHIFT = 30;
  localparam int V1_W = SUM_W + LEN_SHIFT;
  localparam int SQ1_STEPS = V1_W / 2;
  localparam int LEN_W = SQ1_STEPS;
  localparam int NUM_SHIFT = FRAC_BITS + 15;
  localparam int NUM_W = MAG_W + NUM_SHIFT + 1;
  localparam int Q_W = FRAC_BITS + 2;
  localparam int NF_W = 17;
  localparam int V2_W = 2 * FRAC_BITS + 1;
  localparam int SQ2_STEPS = FRAC_BITS + 1;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        eta_ratio;
  } rrv_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               refracts;
  } rrv_out_t;

  typedef struct packed {
    logic                 vld;
    logic [2:0][U_W-1:0]  u;
    logic [2:0][15:0]     n;
    logic [15:0]          eta;
  } rrv_mid_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } rrv_sqrt_t;

  function automatic rrv_sqrt_t sqrt_step(rrv_sqrt_t x, int k);
    rrv_sqrt_t y;
    logic [63:0] b;
    b = 64'd1 << (2 * k);
    y = x;
    if (x.v >= x.r + b) begin
      y.v = x.v - (x.r + b);
      y.r = (x.r >> 1) + b;
    end else begin
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
    logic [63:0] m;
    m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rrv_front.sv
`default_nettype none
module rrv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rrv_pkg::rrv_in_t  in_data,
  output rrv_pkg::rrv_mid_t mid_o
);

  localparam int NS1 = rrv_pkg::SQ1_STEPS + 1;
  localparam int NDV = rrv_pkg::Q_W + 1;
  localparam int V1_W = rrv_pkg::V1_W;
  localparam int NUM_W = rrv_pkg::NUM_W;
  localparam int Q_W = rrv_pkg::Q_W;
  localparam int U_W = rrv_pkg::U_W;
  localparam int LEN_W = rrv_pkg::LEN_W;
  localparam int SQR_W = rrv_pkg::SQR_W;
  localparam int SUM_W = rrv_pkg::SUM_W;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic [2:0][15:0] n;
    logic [15:0]      eta;
  } fc_t;

  logic                   a_vld_r;
  fc_t                    a_c_r, a_c_nxt;
  logic [2:0][SQR_W-1:0]  a_sq_r, a_sq_nxt;

  logic [NS1-1:0]         s_vld_r;
  fc_t                    s_c_r [NS1];
  logic [V1_W-1:0]        s_v_r [NS1];
  logic [V1_W-1:0]        s_v_nxt [NS1];
  logic [V1_W-1:0]        s_rt_r [NS1];
  logic [V1_W-1:0]        s_rt_nxt [NS1];

  logic [NDV-1:0]         q_vld_r;
  fc_t                    q_c_r [NDV];
  logic [LEN_W-1:0]       q_len_r [NDV];
  logic [LEN_W-1:0]       q_len_nxt;
  logic [2:0][NUM_W-1:0]  q_rem_r [NDV];
  logic [2:0][NUM_W-1:0]  q_rem_nxt [NDV];
  logic [2:0][Q_W-1:0]    q_q_r [NDV];
  logic [2:0][Q_W-1:0]    q_q_nxt [NDV];

  logic                   mid_vld_r;
  rrv_pkg::rrv_mid_t      mid_r, mid_nxt;

  // squares and magnitudes
  always_comb begin
    logic [2:0][15:0] d;
    logic [31:0] p;
    d[0] = in_data.dir_x;
    d[1] = in_data.dir_y;
    d[2] = in_data.dir_z;
    a_c_nxt.n[0] = in_data.norm_x;
    a_c_nxt.n[1] = in_data.norm_y;
    a_c_nxt.n[2] = in_data.norm_z;
    a_c_nxt.eta = in_data.eta_ratio;
    for (int i = 0; i < 3; i++) begin
      a_c_nxt.neg[i] = d[i][15];
      a_c_nxt.mag[i] = d[i][15] ? (16'd0 - d[i]) : d[i];
      p = 32'(a_c_nxt.mag[i]) * 32'(a_c_nxt.mag[i]);
      a_sq_nxt[i] = p[SQR_W-1:0];
    end
  end

  // length square root, one result bit per stage
  always_comb begin
    rrv_pkg::rrv_sqrt_t t;
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a_sq_r[0]) + SUM_W'(a_sq_r[1]) + SUM_W'(a_sq_r[2]);
    s_v_nxt[0] = {sum, {rrv_pkg::LEN_SHIFT{1'b0}}};
    s_rt_nxt[0] = '0;
    for (int j = 1; j < NS1; j++) begin
      t = rrv_pkg::sqrt_step({64'(s_v_r[j-1]), 64'(s_rt_r[j-1])}, rrv_pkg::SQ1_STEPS - j);
      s_v_nxt[j] = t.v[V1_W-1:0];
      s_rt_nxt[j] = t.r[V1_W-1:0];
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [NUM_W-1:0] dvs;
    q_len_nxt = s_rt_r[NS1-1][LEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q_rem_nxt[0][i] = (NUM_W'(s_c_r[NS1-1].mag[i]) << rrv_pkg::NUM_SHIFT)
                        + NUM_W'(q_len_nxt >> 1);
      q_q_nxt[0][i] = '0;
    end
    for (int j = 1; j < NDV; j++) begin
      dvs = NUM_W'(q_len_r[j-1]) << (Q_W - j);
      for (int i = 0; i < 3; i++) begin
        if (q_rem_r[j-1][i] >= dvs) begin
          q_rem_nxt[j][i] = q_rem_r[j-1][i] - dvs;
          q_q_nxt[j][i] = q_q_r[j-1][i] | (Q_W'(1) << (Q_W - j));
        end else begin
          q_rem_nxt[j][i] = q_rem_r[j-1][i];
          q_q_nxt[j][i] = q_q_r[j-1][i];
        end
      end
    end
  end

  // clamp and sign, zero for a zero-length direction
  always_comb begin
    logic [Q_W-1:0] qc;
    logic lz;
    lz = (q_len_r[NDV-1] == '0);
    mid_nxt.vld = 1'b0;
    mid_nxt.n = q_c_r[NDV-1].n;
    mid_nxt.eta = q_c_r[NDV-1].eta;
    for (int i = 0; i < 3; i++) begin
      qc = (q_q_r[NDV-1][i] > Q_W'(rrv_pkg::ONE_VAL)) ? Q_W'(rrv_pkg::ONE_VAL)
                                                        : q_q_r[NDV-1][i];
      if (lz) begin
        mid_nxt.u[i] = '0;
      end else if (q_c_r[NDV-1].neg[i]) begin
        mid_nxt.u[i] = U_W'(0) - U_W'(qc);
      end else begin
        mid_nxt.u[i] = U_W'(qc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      s_vld_r <= '0;
      q_vld_r <= '0;
      mid_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      s_vld_r <= {s_vld_r[NS1-2:0], a_vld_r};
      q_vld_r <= {q_vld_r[NDV-2:0], s_vld_r[NS1-1]};
      mid_vld_r <= q_vld_r[NDV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r <= a_c_nxt;
      a_sq_r <= a_sq_nxt;
      s_c_r[0] <= a_c_r;
      for (int j = 1; j < NS1; j++) s_c_r[j] <= s_c_r[j-1];
      s_v_r <= s_v_nxt;
      s_rt_r <= s_rt_nxt;
      q_c_r[0] <= s_c_r[NS1-1];
      q_len_r[0] <= q_len_nxt;
      for (int j = 1; j < NDV; j++) begin
        q_c_r[j] <= q_c_r[j-1];
        q_len_r[j] <= q_len_r[j-1];
      end
      q_rem_r <= q_rem_nxt;
      q_q_r <= q_q_nxt;
      mid_r <= mid_nxt;
    end
  end

  always_comb begin
    mid_o = mid_r;
    mid_o.vld = mid_vld_r;
  end

endmodule
`default_nettype wire

>>> hw/rtl/rrv_back.sv
`default_nettype none
module rrv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  rrv_pkg::rrv_mid_t mid_i,
  output logic              out_vld,
  output rrv_pkg::rrv_out_t out_data
);

  localparam int F = rrv_pkg::FRAC_BITS;
  localparam int U_W = rrv_pkg::U_W;
  localparam int NF_W = rrv_pkg::NF_W;
  localparam int PW = U_W + 16;
  localparam int DS_W = U_W + 18;
  localparam int DT2_W = 2 * U_W;
  localparam int NDT_W = NF_W + U_W;
  localparam int W_W = ((F + 2 > 17) ? F + 2 : 17) + 1;
  localparam int A_W = W_W + 17;
  localparam int E_W = 33 + F;
  localparam int V2_W = rrv_pkg::V2_W;

  localparam int ST_DS = 1;
  localparam int ST_DF = 2;
  localparam int ST_MQ = 3;
  localparam int ST_KW = 4;
  localparam int ST_E = 5;
  localparam int ST_DC = 6;
  localparam int ST_SQ = 7;
  localparam int ST_O1 = ST_SQ + rrv_pkg::SQ2_STEPS;
  localparam int ST_O2 = ST_O1 + 1;
  localparam int NB = ST_O2 + 1;

  typedef struct packed {
    logic [2:0][U_W-1:0]   u;
    logic [2:0][NF_W-1:0]  n;
    logic [15:0]           eta;
    logic [31:0]           eta2;
    logic [2:0][PW-1:0]    p;
    logic [DS_W-1:0]       dot;
    logic [U_W-1:0]        dt;
    logic [DT2_W-1:0]      dt2;
    logic [2:0][NDT_W-1:0] ndt;
    logic [F:0]            k1;
    logic [2:0][W_W-1:0]   w;
    logic [E_W-1:0]        e2raw;
    logic                  refr;
    logic [V2_W-1:0]       v;
    logic [V2_W-1:0]       r;
    logic [2:0][A_W-1:0]   a;
    logic [2:0][A_W-1:0]   b;
    logic [2:0][15:0]      o;
  } bc_t;

  logic [NB-1:0] vld_r;
  bc_t b_r [NB];
  bc_t b_nxt [NB];

  always_comb begin
    bc_t x;
    rrv_pkg::rrv_sqrt_t sq;
    logic signed [63:0] t;
    logic signed [DT2_W-1:0] dsq;

    // products for the cosine and eta squared
    x = '0;
    x.u = mid_i.u;
    x.eta = mid_i.eta;
    x.eta2 = 32'(mid_i.eta) * 32'(mid_i.eta);
    for (int i = 0; i < 3; i++) begin
      x.n[i] = NF_W'($signed(mid_i.n[i]));
      x.p[i] = PW'($signed(mid_i.u[i])) * PW'($signed(mid_i.n[i]));
    end
    b_nxt[0] = x;

    x = b_r[ST_DS-1];
    t = 64'($signed(x.p[0])) + 64'($signed(x.p[1])) + 64'($signed(x.p[2]));
    x.dot = DS_W'(rrv_pkg::rnd_shift(t, F));
    b_nxt[ST_DS] = x;

    // saturate cosine, face the normal against the ray
    x = b_r[ST_DF-1];
    t = 64'($signed(x.dot));
    if (t > rrv_pkg::ONE_S64) t = rrv_pkg::ONE_S64;
    if (t < -rrv_pkg::ONE_S64) t = -rrv_pkg::ONE_S64;
    if (t > 64'sd0) begin
      t = -t;
      for (int i = 0; i < 3; i++) x.n[i] = NF_W'(-$signed(x.n[i]));
    end
    x.dt = U_W'(t);
    b_nxt[ST_DF] = x;

    x = b_r[ST_MQ-1];
    dsq = DT2_W'($signed(x.dt)) * DT2_W'($signed(x.dt));
    x.dt2 = dsq;
    for (int i = 0; i < 3; i++) begin
      x.ndt[i] = NDT_W'($signed(x.n[i])) * NDT_W'($signed(x.dt));
    end
    b_nxt[ST_MQ] = x;

    x = b_r[ST_KW-1];
    t = rrv_pkg::ONE_S64 - rrv_pkg::rnd_shift(64'(x.dt2), F);
    x.k1 = (F + 1)'(t);
    for (int i = 0; i < 3; i++) begin
      t = 64'($signed(x.u[i])) - rrv_pkg::rnd_shift(64'($signed(x.ndt[i])), F);
      x.w[i] = W_W'(t);
    end
    b_nxt[ST_KW] = x;

    x = b_r[ST_E-1];
    x.e2raw = E_W'(x.eta2) * E_W'(x.k1);
    b_nxt[ST_E] = x;

    // discriminant
    x = b_r[ST_DC-1];
    t = rrv_pkg::ONE_S64 - rrv_pkg::rnd_shift(64'(x.e2raw), 2 * F);
    x.refr = (t > 64'sd0);
    x.v = x.refr ? V2_W'(t <<< F) : '0;
    x.r = '0;
    b_nxt[ST_DC] = x;

    for (int j = 0; j < rrv_pkg::SQ2_STEPS; j++) begin
      x = b_r[ST_SQ+j-1];
      sq = rrv_pkg::sqrt_step({64'(x.v), 64'(x.r)}, F - j);
      x.v = sq.v[V2_W-1:0];
      x.r = sq.r[V2_W-1:0];
      b_nxt[ST_SQ+j] = x;
    end

    x = b_r[ST_O1-1];
    for (int i = 0; i < 3; i++) begin
      x.a[i] = A_W'($signed(x.w[i])) * A_W'($signed({1'b0, x.eta}));
      x.b[i] = A_W'($signed(x.n[i])) * A_W'($signed({1'b0, x.r[F:0]}));
    end
    b_nxt[ST_O1] = x;

    // round, saturate, zero on total internal reflection
    x = b_r[ST_O2-1];
    for (int i = 0; i < 3; i++) begin
      t = rrv_pkg::rnd_shift(64'($signed(x.a[i])) - 64'($signed(x.b[i])), F);
      if (t > 64'sd32767) t = 64'sd32767;
      if (t < -64'sd32768) t = -64'sd32768;
      if (!x.refr) t = '0;
      x.o[i] = t[15:0];
    end
    b_nxt[ST_O2] = x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], mid_i.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= b_nxt;
    end
  end

  assign out_vld = vld_r[NB-1];
  assign out_data.out_x = $signed(b_r[NB-1].o[0]);
  assign out_data.out_y = $signed(b_r[NB-1].o[1]);
  assign out_data.out_z = $signed(b_r[NB-1].o[2]);
  assign out_data.refracts = b_r[NB-1].refr;

endmodule
`default_nettype wire

>>> hw/rtl/ray_refract_vector_core.sv
`default_nettype none
// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   rrv_pkg::rrv_in_t
// out_      output     out_valid / out_stall rrv_pkg::rrv_out_t
//
// one request enters per cycle while the result is not stalled
// most pipeline stages belong to the bit-per-stage length square root, the
// bit-per-stage divider and the bit-per-stage discriminant square root
// synchronous active-low reset clears the valid bits of all stages
// a stalled result freezes the whole pipeline and stalls the input
module ray_refract_vector_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rrv_pkg::rrv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rrv_pkg::rrv_out_t out_data
);

  logic              en;
  rrv_pkg::rrv_mid_t mid;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  rrv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .mid_o   (mid)
  );

  rrv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .mid_i    (mid),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/rrv_checker.sv
`default_nettype none
module rrv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rrv_pkg::rrv_out_t out_data
);

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.refracts) |->
      (out_data.out_x == 16'sd0 && out_data.out_y == 16'sd0 && out_data.out_z == 16'sd0))
    else $error("nonzero direction on total internal reflection");

endmodule

bind ray_refract_vector_core rrv_checker u_rrv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

>>> dv/ray_refract_vector_core_tb.sv
`timescale 1ns / 100ps
module ray_refract_vector_core_tb;

  localparam int LATENCY = 2 * rrv_pkg::FRAC_BITS + 47;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rrv_pkg::rrv_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  rrv_pkg::rrv_out_t out_data;

  rrv_pkg::rrv_out_t refracted_q[$];
  int       n_err;
  int       n_sent;
  int       n_checked;
  int       n_tir;
  int       n_ok;
  int       idle_pct;
  int       hold_req;
  int       hold_ack;
  int       hold_cycles;

  ray_refract_vector_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint rshift_round(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic rrv_pkg::rrv_out_t refract(rrv_pkg::rrv_in_t r);
    rrv_pkg::rrv_out_t o;
    longint one;
    longint d[3];
    longint n[3];
    longint u[3];
    longint unsigned ssq;
    longint unsigned len;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned e2k;
    longint unsigned eta;
    longint dt;
    longint k1;
    longint disc;
    longint sq;
    longint w;
    longint v;
    one = 64'sd1 <<< rrv_pkg::FRAC_BITS;
    d[0] = r.dir_x;
    d[1] = r.dir_y;
    d[2] = r.dir_z;
    n[0] = r.norm_x;
    n[1] = r.norm_y;
    n[2] = r.norm_z;
    eta = r.eta_ratio;
    ssq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    len = int_sqrt(ssq << 30);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        mag = (d[i] < 0) ? -d[i] : d[i];
        q = ((mag << (rrv_pkg::FRAC_BITS + 15)) + len / 2) / len;
        if (q > one) q = one;
        u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    dt = clamp(rshift_round(u[0] * n[0] + u[1] * n[1] + u[2] * n[2], rrv_pkg::FRAC_BITS),
               -one, one);
    if (dt > 0) begin
      for (int i = 0; i < 3; i++) n[i] = -n[i];
      dt = -dt;
    end
    k1 = one - rshift_round(dt * dt, rrv_pkg::FRAC_BITS);
    e2k = eta * eta * longint'(k1);
    e2k = (e2k + (64'd1 << (2 * rrv_pkg::FRAC_BITS - 1))) >> (2 * rrv_pkg::FRAC_BITS);
    disc = one - longint'(e2k);
    o = '0;
    if (disc > 0) begin
      sq = int_sqrt(longint'(disc) << rrv_pkg::FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        w = u[i] - rshift_round(n[i] * dt, rrv_pkg::FRAC_BITS);
        v = clamp(rshift_round(w * longint'(eta) - n[i] * sq, rrv_pkg::FRAC_BITS),
                  -32768, 32767);
        if (i == 0) o.out_x = v[15:0];
        if (i == 1) o.out_y = v[15:0];
        if (i == 2) o.out_z = v[15:0];
      end
      o.refracts = 1'b1;
    end
    return o;
  endfunction

  // receiver side: random stalls plus long hold-offs on demand
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_ack <= 0;
      hold_cycles <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 299;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    rrv_pkg::rrv_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (refracted_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        n_err++;
      end else begin
        exp_r = refracted_q.pop_front();
        n_checked++;
        if (exp_r.refracts) n_ok++;
        else n_tir++;
        if (out_data.out_x !== exp_r.out_x || out_data.out_y !== exp_r.out_y ||
            out_data.out_z !== exp_r.out_z || out_data.refracts !== exp_r.refracts) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_r, out_data);
          n_err++;
        end
      end
    end
  end

  task automatic send_request(rrv_pkg::rrv_in_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    refracted_q.push_back(refract(r));
    n_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (refracted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_norm();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic rrv_pkg::rrv_in_t rand_request();
    rrv_pkg::rrv_in_t r;
    logic [15:0] nx;
    logic [15:0] ny;
    r.dir_x = 16'($urandom);
    r.dir_y = 16'($urandom);
    r.dir_z = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      r.dir_x = $signed(r.dir_x) >>> $urandom_range(15);
      r.dir_y = $signed(r.dir_y) >>> $urandom_range(15);
    end
    // mostly normals with a random main component on one axis and smaller others
    nx = rand_norm();
    ny = $signed(rand_norm()) >>> $urandom_range(2, 8);
    case ($urandom_range(2))
      0: begin r.norm_x = nx; r.norm_y = ny; r.norm_z = rand_norm() >>> 3; end
      1: begin r.norm_y = nx; r.norm_z = ny; r.norm_x = rand_norm() >>> 3; end
      default: begin r.norm_x = rand_norm(); r.norm_y = rand_norm(); r.norm_z = rand_norm(); end
    endcase
    case ($urandom_range(3))
      0: r.eta_ratio = 16'($urandom);
      1: r.eta_ratio = 16'($urandom_range(12000, 16384));
      default: r.eta_ratio = 16'($urandom_range(16384, 24000));
    endcase
    return r;
  endfunction

  function automatic rrv_pkg::rrv_in_t mk(int dx, int dy, int dz, int nx, int ny, int nz,
                                          int e);
    rrv_pkg::rrv_in_t r;
    r.dir_x = 16'(dx);
    r.dir_y = 16'(dy);
    r.dir_z = 16'(dz);
    r.norm_x = 16'(nx);
    r.norm_y = 16'(ny);
    r.norm_z = 16'(nz);
    r.eta_ratio = 16'(e);
    return r;
  endfunction

  task automatic test_directed();
    send_request(mk(0, 0, 0, 0, 0, 16384, 8192));
    send_request(mk(0, 0, 0, 0, 0, 16384, 20000));
    send_request(mk(0, 0, -16384, 0, 0, 16384, 16384));
    send_request(mk(0, 0, 16384, 0, 0, 16384, 12000));
    send_request(mk(16384, 0, -1, 0, 0, 16384, 24000));
    send_request(mk(11585, 0, -11585, 0, 0, 16384, 23170));
    send_request(mk(-32768, -32768, -32768, -16384, -16384, -16384, 65535));
    send_request(mk(32767, 32767, 32767, 16384, 16384, 16384, 0));
    send_request(mk(32767, -32768, 1, 16384, -16384, 16384, 16384));
    send_request(mk(1, 0, 0, 16384, 0, 0, 65535));
    send_request(mk(-1, 0, 0, 16384, 0, 0, 40000));
    send_request(mk(100, 200, -300, 0, 16384, 0, 65535));
    send_request(mk(-32768, 0, 0, -16384, 0, 0, 65535));
    send_request(mk(5000, -7000, 9000, 9459, 9459, 9459, 30000));
    send_request(mk(0, 32767, 0, 0, 0, 0, 16384));
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_request(rand_request());
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 200; i++) send_request(rand_request());
    idle_pct = 21;
  endtask

  task automatic test_sender_pause();
    test_random(20, 21);
    drain_all();
    test_random(20, 21);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    n_err = 0;
    n_sent = 0;
    n_checked = 0;
    n_tir = 0;
    n_ok = 0;
    idle_pct = 21;
    hold_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700, 21);
    test_backpressure();
    test_sender_pause();
    test_random(500, 0);
    test_random(500, 21);
    drain_all();
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    $display("refracted %0d, total internal reflection %0d", n_ok, n_tir);
    if (n_err == 0 && refracted_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rrv_pkg.sv
hw/rtl/rrv_front.sv
hw/rtl/rrv_back.sv
hw/rtl/ray_refract_vector_core.sv
hw/rtl/rrv_checker.sv
dv/ray_refract_vector_core_tb.sv
